// ===== sv/pcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpt_pkg
// Shared types and constants of the perceptron train/classify core.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int WEIGHT_W          = 32;
  localparam int LR_W              = 16;
  localparam logic [15:0] LR_RESET = 16'd655;
  localparam int MAX_FEATURES_DEF  = 64;
  localparam int FEATURE_WIDTH_DEF = 16;
  localparam int IN_TUSER_W        = 3;
  localparam int OUT_TDATA_W       = 8;

  localparam logic [1:0] ERR_ZERO  = 2'b00;
  localparam logic [1:0] ERR_PLUS  = 2'b01;
  localparam logic [1:0] ERR_MINUS = 2'b11;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_TRAIN    = 2'd1,
    FUNC_CLASSIFY = 2'd2,
    FUNC_NOP      = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_BIAS_RD,
    ST_BIAS_ACT,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic rd;
    logic sel_epoch;
    logic wr;
    logic clear;
    logic snap;
  } wcmd_t;

endpackage

// ===== sv/pcpt_weight_store.sv =====
// ----------------------------------------------------------------------------
// pcpt_weight_store
// Live weights and epoch copy in two memories, copy-on-write per entry.
// ----------------------------------------------------------------------------
module pcpt_weight_store #(
  parameter int NW = pcpt_pkg::MAX_FEATURES_DEF + 1,
  parameter int AW = $clog2(NW)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcpt_pkg::wcmd_t                     cmd,
  input  logic [AW-1:0]                       addr,
  input  logic [pcpt_pkg::WEIGHT_W-1:0]       wr_data,
  input  logic [pcpt_pkg::WEIGHT_W-1:0]       wr_old,
  output logic [pcpt_pkg::WEIGHT_W-1:0]       rd_data
);

  logic [pcpt_pkg::WEIGHT_W-1:0] wmem [NW];
  logic [pcpt_pkg::WEIGHT_W-1:0] emem [NW];
  logic [NW-1:0]                 wvalid;
  logic [NW-1:0]                 dirty;
  logic [pcpt_pkg::WEIGHT_W-1:0] w_q;
  logic [pcpt_pkg::WEIGHT_W-1:0] e_q;
  logic [AW-1:0]                 addr_r;
  logic                          sel_q;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      wmem[addr] <= wr_data;
      if (!dirty[addr]) begin
        emem[addr] <= wr_old;
      end
    end
    if (cmd.rd) begin
      w_q    <= wmem[addr];
      e_q    <= emem[addr];
      addr_r <= addr;
      sel_q  <= cmd.sel_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wvalid <= '0;
      dirty  <= '0;
    end else begin
      if (cmd.snap) begin
        dirty <= '0;
      end
      if (cmd.wr) begin
        wvalid[addr] <= 1'b1;
        dirty[addr]  <= 1'b1;
      end
    end
  end

  always_comb begin
    if (sel_q && dirty[addr_r]) begin
      rd_data = e_q;
    end else if (wvalid[addr_r]) begin
      rd_data = w_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== sv/pcpt_sample_buf.sv =====
// ----------------------------------------------------------------------------
// pcpt_sample_buf
// Feature store of the current sample, one write and one registered read.
// ----------------------------------------------------------------------------
module pcpt_sample_buf #(
  parameter int DEPTH = pcpt_pkg::MAX_FEATURES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW    = pcpt_pkg::FEATURE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/perceptron_train_classify_core.sv =====
// ----------------------------------------------------------------------------
// perceptron_train_classify_core
// Streamed perceptron: multiply-accumulate per feature, weight update per training miss.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// cfg      in   cfg_valid/ready    cfg_data = learn_rate
// s        in   s_tvalid/tready    s_tdata, s_tuser, s_tlast
// m        out  m_tvalid/tready    m_tdata
//
// A feature element passes through accept with weight read, multiply, accumulate.
// A last element adds bias read, activation and result register; a training
// miss adds a read-modify-write of the weight memory per weight entry (bias
// plus stored features). Reset is immediate: per-entry flags make weights read
// as zero, no clearing pass. A stalled result holds in the output register; the
// next item is taken meanwhile.
// ----------------------------------------------------------------------------
module perceptron_train_classify_core #(
  parameter int  MAX_FEATURES  = pcpt_pkg::MAX_FEATURES_DEF,
  parameter int  FEATURE_WIDTH = pcpt_pkg::FEATURE_WIDTH_DEF,
  localparam int IN_TDATA_W    = ((FEATURE_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcpt_pkg::LR_W-1:0]        cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [IN_TDATA_W-1:0]            s_tdata,   // feature, label, zero pad
  input  logic [pcpt_pkg::IN_TUSER_W-1:0]  s_tuser,   // func[1:0], epoch_start
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pcpt_pkg::OUT_TDATA_W-1:0] m_tdata    // predicted_class, error[1:0],
                                                      // saturated, zero pad
);

  localparam int NW        = MAX_FEATURES + 1;
  localparam int AW        = $clog2(NW);
  localparam int SAW       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int WW        = pcpt_pkg::WEIGHT_W;
  localparam int LW        = pcpt_pkg::LR_W;
  localparam int FRAC      = FEATURE_WIDTH - 1;
  localparam int PROD_W    = WW + FEATURE_WIDTH;
  localparam int TERM_W    = PROD_W - FRAC;
  localparam int ACC_W     = TERM_W + AW + 1;
  localparam int STEP_W    = LW + 1 + FEATURE_WIDTH;
  localparam int STEP_SH_W = STEP_W - FRAC;
  localparam int SUM_W     = WW + 2;

  pcpt_pkg::state_t state, state_next;
  pcpt_pkg::wcmd_t  wcmd;
  pcpt_pkg::func_t  in_func;
  pcpt_pkg::func_t  func_r;

  logic                            accept;
  logic                            in_epoch;
  logic signed [FEATURE_WIDTH-1:0] in_feature;
  logic                            in_label;
  logic                            idx_in_range;

  logic [LW-1:0]                   learn_rate;
  logic [AW-1:0]                   idx;
  logic signed [ACC_W-1:0]         acc;
  logic                            label_r;
  logic                            last_r;
  logic signed [FEATURE_WIDTH-1:0] feat_r;
  logic                            in_range_r;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        prod_sh;
  logic [TERM_W-1:0]               term;
  logic [AW-1:0]                   n_r;
  logic [AW-1:0]                   k;
  logic                            pred_r;
  logic                            err_neg_r;
  logic                            sat_r;
  logic signed [WW-1:0]            w_old;
  logic signed [STEP_SH_W-1:0]     step_r;

  logic [AW-1:0]                   waddr;
  logic [WW-1:0]                   wr_data;
  logic signed [WW-1:0]            w_rd;
  logic                            sb_wr;
  logic                            sb_rd;
  logic [SAW-1:0]                  sb_raddr;
  logic [AW-1:0]                   k_prev;
  logic signed [FEATURE_WIDTH-1:0] sb_data;

  logic signed [ACC_W-1:0]         act;
  logic                            pred;
  logic signed [STEP_W-1:0]        step_prod;
  logic signed [STEP_W-1:0]        step_sh;
  logic signed [SUM_W-1:0]         w_ext;
  logic signed [SUM_W-1:0]         step_ext;
  logic signed [SUM_W-1:0]         sum_full;
  logic                            clip;
  logic                            res_pred;
  logic [1:0]                      res_err;
  logic                            res_sat;

  assign cfg_ready    = 1'b1;
  assign s_tready     = (state == pcpt_pkg::ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign in_func      = pcpt_pkg::func_t'(s_tuser[1:0]);
  assign in_epoch     = s_tuser[2];
  assign in_feature   = s_tdata[FEATURE_WIDTH-1:0];
  assign in_label     = s_tdata[FEATURE_WIDTH];
  assign idx_in_range = (idx < AW'(MAX_FEATURES));
  assign m_tdata      = {{(pcpt_pkg::OUT_TDATA_W - 4){1'b0}}, res_sat, res_err, res_pred};

  assign prod_sh   = prod >>> FRAC;
  assign term      = prod_sh[TERM_W-1:0];
  assign act       = acc + {{(ACC_W - WW){w_rd[WW-1]}}, w_rd};
  assign pred      = ~act[ACC_W-1];
  assign step_prod = $signed({1'b0, learn_rate}) * sb_data;
  assign step_sh   = step_prod >>> FRAC;
  assign k_prev    = k - AW'(1);
  assign sb_raddr  = k_prev[SAW-1:0];

  assign w_ext    = {{(SUM_W - WW){w_old[WW-1]}}, w_old};
  assign step_ext = {{(SUM_W - STEP_SH_W){step_r[STEP_SH_W-1]}}, step_r};
  assign sum_full = err_neg_r ? (w_ext - step_ext) : (w_ext + step_ext);
  assign clip     = (sum_full[SUM_W-1:WW-1] != '0) && (sum_full[SUM_W-1:WW-1] != '1);

  always_comb begin
    if (!clip) begin
      wr_data = sum_full[WW-1:0];
    end else if (sum_full[SUM_W-1]) begin
      wr_data = {1'b1, {(WW - 1){1'b0}}};
    end else begin
      wr_data = {1'b0, {(WW - 1){1'b1}}};
    end
  end

  pcpt_weight_store #(
    .NW(NW),
    .AW(AW)
  ) u_wstore (
    .clk     (clk),
    .rst     (rst),
    .cmd     (wcmd),
    .addr    (waddr),
    .wr_data (wr_data),
    .wr_old  (w_old),
    .rd_data (w_rd)
  );

  pcpt_sample_buf #(
    .DEPTH(MAX_FEATURES),
    .AW   (SAW),
    .DW   (FEATURE_WIDTH)
  ) u_sbuf (
    .clk     (clk),
    .wr_en   (sb_wr),
    .wr_addr (idx[SAW-1:0]),
    .wr_data (in_feature),
    .rd_en   (sb_rd),
    .rd_addr (sb_raddr),
    .rd_data (sb_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wcmd       = '0;
    waddr      = '0;
    sb_wr      = 1'b0;
    sb_rd      = 1'b0;
    unique case (state)
      pcpt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == pcpt_pkg::FUNC_CLEAR) begin
            wcmd.clear = 1'b1;
          end else if (in_func == pcpt_pkg::FUNC_TRAIN ||
                       in_func == pcpt_pkg::FUNC_CLASSIFY) begin
            wcmd.snap      = in_epoch;
            wcmd.rd        = idx_in_range;
            wcmd.sel_epoch = (in_func == pcpt_pkg::FUNC_TRAIN);
            waddr          = idx + AW'(1);
            sb_wr          = idx_in_range;
            state_next     = pcpt_pkg::ST_MAC_MUL;
          end
        end
      end
      pcpt_pkg::ST_MAC_MUL: begin
        state_next = pcpt_pkg::ST_MAC_ACC;
      end
      pcpt_pkg::ST_MAC_ACC: begin
        state_next = last_r ? pcpt_pkg::ST_BIAS_RD : pcpt_pkg::ST_IDLE;
      end
      pcpt_pkg::ST_BIAS_RD: begin
        wcmd.rd        = 1'b1;
        wcmd.sel_epoch = (func_r == pcpt_pkg::FUNC_TRAIN);
        state_next     = pcpt_pkg::ST_BIAS_ACT;
      end
      pcpt_pkg::ST_BIAS_ACT: begin
        if (func_r == pcpt_pkg::FUNC_TRAIN && label_r != pred) begin
          state_next = pcpt_pkg::ST_UPD_RD;
        end else begin
          state_next = pcpt_pkg::ST_RESULT;
        end
      end
      pcpt_pkg::ST_UPD_RD: begin
        wcmd.rd    = 1'b1;
        waddr      = k;
        sb_rd      = (k != '0);
        state_next = pcpt_pkg::ST_UPD_MUL;
      end
      pcpt_pkg::ST_UPD_MUL: begin
        state_next = pcpt_pkg::ST_UPD_WR;
      end
      pcpt_pkg::ST_UPD_WR: begin
        wcmd.wr    = 1'b1;
        waddr      = k;
        state_next = (k == n_r) ? pcpt_pkg::ST_RESULT : pcpt_pkg::ST_UPD_RD;
      end
      pcpt_pkg::ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = pcpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= pcpt_pkg::LR_RESET;
      idx        <= '0;
      acc        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        learn_rate <= cfg_data;
      end
      if (state == pcpt_pkg::ST_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pcpt_pkg::ST_IDLE: begin
          if (accept && in_func == pcpt_pkg::FUNC_CLEAR) begin
            idx <= '0;
            acc <= '0;
          end else if (accept && idx_in_range &&
                       (in_func == pcpt_pkg::FUNC_TRAIN ||
                        in_func == pcpt_pkg::FUNC_CLASSIFY)) begin
            idx <= idx + AW'(1);
          end
        end
        pcpt_pkg::ST_MAC_ACC: begin
          if (in_range_r) begin
            acc <= acc + {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};
          end
        end
        pcpt_pkg::ST_BIAS_ACT: begin
          acc <= '0;
          idx <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pcpt_pkg::ST_IDLE: begin
        if (accept) begin
          func_r     <= in_func;
          label_r    <= in_label;
          last_r     <= s_tlast;
          feat_r     <= in_feature;
          in_range_r <= idx_in_range;
        end
      end
      pcpt_pkg::ST_MAC_MUL: begin
        prod <= w_rd * feat_r;
      end
      pcpt_pkg::ST_BIAS_ACT: begin
        n_r       <= idx;
        pred_r    <= pred;
        err_neg_r <= ~label_r;
        k         <= '0;
        sat_r     <= 1'b0;
      end
      pcpt_pkg::ST_UPD_MUL: begin
        w_old <= w_rd;
        if (k == '0) begin
          step_r <= {{(STEP_SH_W - LW){1'b0}}, learn_rate};
        end else begin
          step_r <= step_sh[STEP_SH_W-1:0];
        end
      end
      pcpt_pkg::ST_UPD_WR: begin
        sat_r <= sat_r | clip;
        k     <= k + AW'(1);
      end
      pcpt_pkg::ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          res_pred <= pred_r;
          res_sat  <= sat_r;
          if (func_r != pcpt_pkg::FUNC_TRAIN || label_r == pred_r) begin
            res_err <= pcpt_pkg::ERR_ZERO;
          end else if (err_neg_r) begin
            res_err <= pcpt_pkg::ERR_MINUS;
          end else begin
            res_err <= pcpt_pkg::ERR_PLUS;
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= AW'(MAX_FEATURES))
    else $error("element index beyond feature count");

  a_upd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcpt_pkg::ST_UPD_RD || state == pcpt_pkg::ST_UPD_MUL ||
     state == pcpt_pkg::ST_UPD_WR) |-> k <= n_r)
    else $error("update index beyond sample length");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == pcpt_pkg::ST_RESULT && m_tvalid && !m_tready) |=>
      (state == pcpt_pkg::ST_RESULT && m_tvalid))
    else $error("result register overwritten while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && in_func == pcpt_pkg::FUNC_CLEAR) |=> (idx == '0 && acc == '0))
    else $error("clear did not reset sample state");

endmodule
